[design/s2e_pkg.sv]
// Shared constants and types for the symmetric 2x2 eigenvalue core.
package s2e_pkg;

  // Queue depths, powers of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 2;

  // Status of one queue, seen by its producer and consumer.
  typedef struct packed {
    logic empty;
    logic full;
  } s2e_fifo_stat_t;

endpackage

[design/sym2x2_eigenvalues_core.sv]
// Top level of the symmetric 2x2 eigenvalue core.
//
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | in_diag_first, in_off_diag, in_diag_second
//  result   | empty / pop        | out_eig_large, out_eig_small, out_overflow
//
// One matrix per cycle sustained while the consumer keeps popping results.
// The back end holds the root pipeline (DATA_WIDTH+1 stages, one root bit
// each) and the long divider (2*DATA_WIDTH stages, one quotient bit each).
// Reset is synchronous, active low; it clears valids and queue pointers and counts only.
// A stalled result queue freezes the back pipeline; the front keeps filling
// the middle queue until it too is full, then full rises.
module sym2x2_eigenvalues_core
  import s2e_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] in_diag_first,
  input  logic signed [DATA_WIDTH-1:0] in_off_diag,
  input  logic signed [DATA_WIDTH-1:0] in_diag_second,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] out_eig_large,
  output logic signed [DATA_WIDTH-1:0] out_eig_small,
  output logic                         out_overflow
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned QDW = 7 * W + 3;   // front-to-back beat
  localparam int unsigned ODW = 2 * W + 1;   // result beat

  // front -> middle queue
  s2e_fifo_stat_t   q_stat;
  logic             q_push, q_pop;
  logic [QDW-1:0]   q_wdata, q_rdata;

  // back -> result queue
  s2e_fifo_stat_t   o_stat;
  logic             o_push;
  logic [W-1:0]     o_large, o_small;
  logic             o_ovf;
  logic [ODW-1:0]   o_rdata;

  // Front: registers the beat with its sum, difference square and products.
  s2e_front #(.W(W)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .diag_first  (in_diag_first),
    .off_diag    (in_off_diag),
    .diag_second (in_diag_second),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Short queue so front and back stall independently.
  s2e_fifo #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: root, first eigenvalue, division, saturation.
  s2e_back #(.W(W)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .o_stat  (o_stat),
    .o_push  (o_push),
    .o_large (o_large),
    .o_small (o_small),
    .o_ovf   (o_ovf)
  );

  // Result queue: parts the pipeline from the consumer.
  s2e_fifo #(.WIDTH(ODW), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata ({o_ovf, o_large, o_small}),
    .pop   (pop),
    .rdata (o_rdata),
    .stat  (o_stat)
  );

  assign empty         = o_stat.empty;
  assign out_overflow  = o_rdata[ODW-1];
  assign out_eig_large = o_rdata[ODW-2:W];
  assign out_eig_small = o_rdata[W-1:0];

endmodule

[design/s2e_fifo.sv]
// Small register queue with fill count, used between the core's parts.
module s2e_fifo
  import s2e_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output s2e_fifo_stat_t       stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[design/s2e_front.sv]
// Front end: takes a matrix beat, forms sum, products and squared difference.
module s2e_front
  import s2e_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic signed [W-1:0]   diag_first,
  input  logic signed [W-1:0]   off_diag,
  input  logic signed [W-1:0]   diag_second,
  input  s2e_fifo_stat_t        q_stat,
  output logic                  q_push,
  output logic [7*W+2:0]        q_data
);

  localparam int unsigned QW = 2 * W;
  localparam int unsigned SW = 2 * W + 2;

  logic                 f_v_r, f_v_nxt;
  logic                 load;
  logic signed [W:0]    sm, df;
  logic signed [QW-1:0] ac, bb;
  logic signed [SW-1:0] dfsq;
  logic [W:0]           sm_r;
  logic [QW-1:0]        ac_r, bb_r;
  logic [SW-1:0]        dfsq_r;

  assign full    = f_v_r && q_stat.full;
  assign q_push  = f_v_r && !q_stat.full;
  assign load    = push && !full;
  assign f_v_nxt = load || (f_v_r && q_stat.full);

  assign sm   = {diag_first[W-1], diag_first} + {diag_second[W-1], diag_second};
  assign df   = {diag_first[W-1], diag_first} - {diag_second[W-1], diag_second};
  assign ac   = diag_first * diag_second;
  assign bb   = off_diag * off_diag;
  assign dfsq = df * df;

  assign q_data = {sm_r, ac_r, bb_r, dfsq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
    if (load) begin
      sm_r   <= sm;
      ac_r   <= ac;
      bb_r   <= bb;
      dfsq_r <= dfsq;
    end
  end

endmodule

[design/s2e_back.sv]
// Back end: root, first eigenvalue, long division and saturation pipeline.
module s2e_back
  import s2e_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  s2e_fifo_stat_t    q_stat,
  input  logic [7*W+2:0]    q_data,
  output logic              q_pop,
  input  s2e_fifo_stat_t    o_stat,
  output logic              o_push,
  output logic [W-1:0]      o_large,
  output logic [W-1:0]      o_small,
  output logic              o_ovf
);

  localparam int unsigned RW   = W + 1;       // root bits
  localparam int unsigned SW   = 2 * RW;      // sum of squares
  localparam int unsigned REMW = RW + 3;      // root remainder
  localparam int unsigned QW   = 2 * W;       // det magnitude / quotient
  localparam int unsigned LW   = W + 2;       // first eigenvalue magnitude
  localparam int unsigned DETW = 2 * W + 1;   // signed determinant

  // ---------------- flow ----------------
  logic adv;
  logic fin_v_r;
  assign adv    = !(fin_v_r && o_stat.full);
  assign q_pop  = adv && !q_stat.empty;
  assign o_push = fin_v_r && !o_stat.full;

  // ---------------- unpack queue beat ----------------
  logic [W:0]    in_sm;
  logic [QW-1:0] in_ac, in_bb;
  logic [SW-1:0] in_dfsq;
  assign {in_sm, in_ac, in_bb, in_dfsq} = q_data;

  // ---------------- P0: sum of squares, determinant ----------------
  logic            p_v_r;
  logic [SW-1:0]   p_s_r;
  logic [DETW-1:0] p_det_r;
  logic [W:0]      p_sm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= !q_stat.empty;
    end
    if (adv) begin
      p_s_r   <= in_dfsq + {in_bb, 2'b00};
      p_det_r <= {in_ac[QW-1], in_ac} - {1'b0, in_bb};
      p_sm_r  <= in_sm;
    end
  end

  // ---------------- root: one bit per stage ----------------
  logic            sq_v_r    [RW];
  logic [REMW-1:0] sq_rem_r  [RW];
  logic [RW-1:0]   sq_root_r [RW];
  logic [SW-1:0]   sq_s_r    [RW];
  logic [W:0]      sq_sm_r   [RW];
  logic [DETW-1:0] sq_det_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sq
    logic            v_in;
    logic [REMW-1:0] rem_in, shifted, trial, rem_nxt;
    logic [RW-1:0]   root_in, root_nxt;
    logic [SW-1:0]   s_in;
    logic [W:0]      sm_in;
    logic [DETW-1:0] det_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = p_v_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = p_s_r;
      assign sm_in   = p_sm_r;
      assign det_in  = p_det_r;
    end else begin : g_next
      assign v_in    = sq_v_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign s_in    = sq_s_r[k-1];
      assign sm_in   = sq_sm_r[k-1];
      assign det_in  = sq_det_r[k-1];
    end

    assign shifted  = {rem_in[REMW-3:0], s_in[2*(RW-1-k)+1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (shifted >= trial);
    assign rem_nxt  = ge ? shifted - trial : shifted;
    assign root_nxt = {root_in[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k] <= v_in;
      end
      if (adv) begin
        sq_rem_r[k]  <= rem_nxt;
        sq_root_r[k] <= root_nxt;
        sq_s_r[k]    <= s_in;
        sq_sm_r[k]   <= sm_in;
        sq_det_r[k]  <= det_in;
      end
    end
  end

  // ---------------- R: round root to nearest ----------------
  logic            r_v_r;
  logic [RW-1:0]   r_rt_r;
  logic [W:0]      r_sm_r;
  logic [DETW-1:0] r_det_r;
  logic            r_up;

  // round up when the remainder exceeds the floor root
  assign r_up = (sq_rem_r[RW-1] > {3'b000, sq_root_r[RW-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= sq_v_r[RW-1];
    end
    if (adv) begin
      r_rt_r  <= sq_root_r[RW-1] + RW'(r_up);
      r_sm_r  <= sq_sm_r[RW-1];
      r_det_r <= sq_det_r[RW-1];
    end
  end

  // ---------------- L: first eigenvalue, det magnitude ----------------
  logic [W+2:0]    l_smx, l_rtx, l_v, l_vm;
  logic [W+3:0]    l_vm1;
  logic            l_zs, l_neg_c, l_dneg_c;
  logic [LW-1:0]   l_lm_c;
  logic [DETW-1:0] l_dabs;

  assign l_smx   = {{2{r_sm_r[W]}}, r_sm_r};
  assign l_rtx   = {2'b00, r_rt_r};
  assign l_zs    = (r_sm_r == '0);
  // zero sum: first eigenvalue is half the root, positive
  assign l_v     = l_zs ? l_rtx : (r_sm_r[W] ? l_smx - l_rtx : l_smx + l_rtx);
  assign l_neg_c = l_v[W+2];
  assign l_vm    = l_neg_c ? -l_v : l_v;
  assign l_vm1   = {1'b0, l_vm} + (W+4)'(1);
  assign l_lm_c  = l_vm1[LW:1];
  assign l_dneg_c = r_det_r[DETW-1];
  assign l_dabs   = l_dneg_c ? -r_det_r : r_det_r;

  logic            l_v_r, l_neg_r, l_dneg_r, l_zs_r;
  logic [LW-1:0]   l_lm_r, l_dv_r;
  logic [QW-1:0]   l_dm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
    end else if (adv) begin
      l_v_r <= r_v_r;
    end
    if (adv) begin
      l_lm_r   <= l_lm_c;
      l_dv_r   <= l_zs ? LW'(1) : l_lm_c;
      l_neg_r  <= l_neg_c;
      l_dm_r   <= l_dabs[QW-1:0];
      l_dneg_r <= l_dneg_c;
      l_zs_r   <= l_zs;
    end
  end

  // ---------------- division: one quotient bit per stage ----------------
  logic          d_v_r    [QW];
  logic [LW-1:0] d_rem_r  [QW];
  logic [QW-1:0] d_q_r    [QW];
  logic [QW-1:0] d_dm_r   [QW];
  logic [LW-1:0] d_dv_r   [QW];
  logic [LW-1:0] d_lm_r   [QW];
  logic          d_neg_r  [QW];
  logic          d_dneg_r [QW];
  logic          d_zs_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic          v_in, neg_in, dneg_in, zs_in, ge;
    logic [LW-1:0] rem_in, dv_in, lm_in, rem_nxt;
    logic [QW-1:0] q_in, dm_in;
    logic [LW:0]   trial, diff;

    if (j == 0) begin : g_first
      assign v_in    = l_v_r;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign dm_in   = l_dm_r;
      assign dv_in   = l_dv_r;
      assign lm_in   = l_lm_r;
      assign neg_in  = l_neg_r;
      assign dneg_in = l_dneg_r;
      assign zs_in   = l_zs_r;
    end else begin : g_next
      assign v_in    = d_v_r[j-1];
      assign rem_in  = d_rem_r[j-1];
      assign q_in    = d_q_r[j-1];
      assign dm_in   = d_dm_r[j-1];
      assign dv_in   = d_dv_r[j-1];
      assign lm_in   = d_lm_r[j-1];
      assign neg_in  = d_neg_r[j-1];
      assign dneg_in = d_dneg_r[j-1];
      assign zs_in   = d_zs_r[j-1];
    end

    assign trial   = {rem_in, dm_in[QW-1-j]};
    assign ge      = (trial >= {1'b0, dv_in});
    assign diff    = trial - {1'b0, dv_in};
    assign rem_nxt = ge ? diff[LW-1:0] : trial[LW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[j] <= 1'b0;
      end else if (adv) begin
        d_v_r[j] <= v_in;
      end
      if (adv) begin
        d_rem_r[j]  <= rem_nxt;
        d_q_r[j]    <= {q_in[QW-2:0], ge};
        d_dm_r[j]   <= dm_in;
        d_dv_r[j]   <= dv_in;
        d_lm_r[j]   <= lm_in;
        d_neg_r[j]  <= neg_in;
        d_dneg_r[j] <= dneg_in;
        d_zs_r[j]   <= zs_in;
      end
    end
  end

  // ---------------- Q: round quotient half away from zero ----------------
  logic          qs_v_r, qs_neg_r, qs_dneg_r, qs_zs_r;
  logic [QW:0]   qs_q_r;
  logic [LW-1:0] qs_lm_r;
  logic          qs_up;

  assign qs_up = ({d_rem_r[QW-1], 1'b0} >= {1'b0, d_dv_r[QW-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_v_r <= 1'b0;
    end else if (adv) begin
      qs_v_r <= d_v_r[QW-1];
    end
    if (adv) begin
      qs_q_r    <= {1'b0, d_q_r[QW-1]} + (QW+1)'(qs_up);
      qs_lm_r   <= d_lm_r[QW-1];
      qs_neg_r  <= d_neg_r[QW-1];
      qs_dneg_r <= d_dneg_r[QW-1];
      qs_zs_r   <= d_zs_r[QW-1];
    end
  end

  // ---------------- F: saturate ----------------
  localparam logic [QW:0] HALF = {{(W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // returns {overflow, value}
  function automatic logic [W:0] sat_fn(input logic neg, input logic [QW:0] mag);
    logic [QW:0] m;
    logic        ov;
    logic [QW:0] nm;
    m  = mag;
    ov = 1'b0;
    if (neg) begin
      if (mag > HALF) begin
        m  = HALF;
        ov = 1'b1;
      end
      nm = -m;
      return {ov, nm[W-1:0]};
    end
    if (mag > HALF - (QW+1)'(1)) begin
      m  = HALF - (QW+1)'(1);
      ov = 1'b1;
    end
    return {ov, m[W-1:0]};
  endfunction

  logic [QW:0] f_lmx;
  logic [W:0]  f_large, f_small;

  assign f_lmx   = {{(QW+1-LW){1'b0}}, qs_lm_r};
  assign f_large = sat_fn(qs_neg_r, f_lmx);
  assign f_small = qs_zs_r ? sat_fn(qs_lm_r != '0, f_lmx)
                           : sat_fn((qs_q_r != '0) && (qs_dneg_r != qs_neg_r), qs_q_r);

  logic [W-1:0] fin_large_r, fin_small_r;
  logic         fin_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= qs_v_r;
    end
    if (adv) begin
      fin_large_r <= f_large[W-1:0];
      fin_small_r <= f_small[W-1:0];
      fin_ovf_r   <= f_large[W] | f_small[W];
    end
  end

  assign o_large = fin_large_r;
  assign o_small = fin_small_r;
  assign o_ovf   = fin_ovf_r;

  // ---------------- checks ----------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> fin_v_r)
    else $error("result stage lost a beat while stalled");

  a_load_p0: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> p_v_r)
    else $error("queue popped but first stage not loaded");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> (fin_v_r && !o_stat.full))
    else $error("result pushed into full queue");

endmodule

[tb/sv/sym2x2_eigenvalues_checker.sv]
`timescale 1ns / 1ps
// Checker for the 2x2 eigenvalue core: predicts each result beat and compares it.
module sym2x2_eigenvalues_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic signed [DATA_WIDTH-1:0] in_diag_first,
  input  logic signed [DATA_WIDTH-1:0] in_off_diag,
  input  logic signed [DATA_WIDTH-1:0] in_diag_second,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [DATA_WIDTH-1:0] out_eig_large,
  input  logic signed [DATA_WIDTH-1:0] out_eig_small,
  input  logic                         out_overflow,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] large_eig;
    logic [DATA_WIDTH-1:0] small_eig;
    logic                  ovf;
  } eig_pair_t;

  eig_pair_t eig_queue[$];

  // Nearest-rounded integer root; s < 2^67.
  function automatic logic [63:0] root_round(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    r = 0;
    for (int i = 35; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    if (s > 128'(r) * 128'(r) + 128'(r)) r++;
    return r;
  endfunction

  // Clamp a signed magnitude to the output range, flagging overflow.
  function automatic logic [DATA_WIDTH-1:0] clamp(logic neg, logic [127:0] mag,
                                                  ref logic ovf);
    logic [127:0] half;
    half = 128'd1 << (DATA_WIDTH - 1);
    if (neg) begin
      if (mag > half) begin
        mag = half;
        ovf = 1'b1;
      end
      return DATA_WIDTH'(-mag);
    end
    if (mag > half - 1) begin
      mag = half - 1;
      ovf = 1'b1;
    end
    return DATA_WIDTH'(mag);
  endfunction

  function automatic eig_pair_t predict_eigs(logic signed [DATA_WIDTH-1:0] a_in,
                                             logic signed [DATA_WIDTH-1:0] b_in,
                                             logic signed [DATA_WIDTH-1:0] c_in);
    logic signed [127:0] a, b, c, sm, df, tb, rt, l1, v, det;
    logic [127:0] lm, dm, q, r, hm;
    logic ovf;
    eig_pair_t res;
    a = a_in;
    b = b_in;
    c = c_in;
    sm = a + c;
    df = a - c;
    tb = 2 * b;
    rt = root_round(df * df + tb * tb);
    ovf = 1'b0;
    if (sm == 0) begin
      hm = (rt + 1) >> 1;
      res.large_eig = clamp(1'b0, hm, ovf);
      res.small_eig = clamp(hm != 0, hm, ovf);
    end else begin
      v = (sm < 0) ? sm - rt : sm + rt;
      hm = ((v < 0 ? -v : v) + 1) >> 1;
      l1 = (v < 0) ? -hm : hm;
      det = a * c - b * b;
      dm = det < 0 ? -det : det;
      lm = hm;
      q = dm / lm;
      r = dm % lm;
      if (r >= lm - r) q++;
      res.large_eig = clamp(l1 < 0, lm, ovf);
      res.small_eig = clamp(q != 0 && ((det < 0) != (l1 < 0)), q, ovf);
    end
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    eig_pair_t want;
    if (!rst_n) begin
      fail_count = 0;
      eig_queue.delete();
    end else begin
      if (push && !full)
        eig_queue.push_back(predict_eigs(in_diag_first, in_off_diag, in_diag_second));
      if (pop && !empty) begin
        if (eig_queue.size() == 0) begin
          $display("%0t: result beat with no matrix outstanding", $realtime);
          fail_count++;
        end else begin
          want = eig_queue.pop_front();
          if (out_eig_large !== want.large_eig)
            report_mismatch("eig_large", out_eig_large, want.large_eig);
          if (out_eig_small !== want.small_eig)
            report_mismatch("eig_small", out_eig_small, want.small_eig);
          if (out_overflow !== want.ovf)
            report_mismatch("overflow", DATA_WIDTH'(out_overflow), DATA_WIDTH'(want.ovf));
        end
      end
    end
    pending = eig_queue.size();
  end

endmodule

[tb/sv/sym2x2_eigenvalues_core_test.sv]
`timescale 1ns / 1ps
// Top of the 2x2 eigenvalue core testbench: stimulus, idling phases and verdict.
module sym2x2_eigenvalues_core_test;

  localparam int unsigned DW = 32;
  // Drain margin, well above the core's pipeline length.
  localparam int DRAIN = 3 * DW + 40;
  // Cycles with no beat on either side before giving up.
  localparam int STALL_LIMIT = 5000;
  // Receiver hold-off length; long enough for the core to fill up.
  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, out_overflow;
  logic signed [DW-1:0] in_diag_first = '0;
  logic signed [DW-1:0] in_off_diag = '0;
  logic signed [DW-1:0] in_diag_second = '0;
  logic signed [DW-1:0] out_eig_large, out_eig_small;
  int fail_count, pending;

  // Idle percentages per side; the receiver hold-off overrides pop entirely.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sym2x2_eigenvalues_core #(.DATA_WIDTH(DW)) uut (
    .clk, .rst_n, .push, .full, .in_diag_first, .in_off_diag, .in_diag_second,
    .empty, .pop, .out_eig_large, .out_eig_small, .out_overflow
  );

  sym2x2_eigenvalues_checker #(.DATA_WIDTH(DW)) checker_i (
    .clk, .rst_n, .push, .full, .in_diag_first, .in_off_diag, .in_diag_second,
    .empty, .pop, .out_eig_large, .out_eig_small, .out_overflow,
    .fail_count, .pending
  );

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("sym2x2_eigenvalues_core_test failed");
      $finish;
    end
  end

  // Offer one matrix; hold it until accepted. push stays high afterwards.
  task automatic send_matrix(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_diag_first <= a;
    in_off_diag <= b;
    in_diag_second <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Random field, biased toward small values, extremes and sign edges.
  function automatic logic [DW-1:0] rand_entry();
    case ($urandom_range(7))
      0: return $urandom;
      1: return DW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return {1'b0, {(DW-1){1'b1}}} - DW'($urandom_range(3));
      3: return {1'b1, {(DW-1){1'b0}}} + DW'($urandom_range(3));
      4: return DW'($signed($urandom_range(0, 64)) - 32);
      default: return DW'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE  = 1 << 16;

  initial begin
    logic [DW-1:0] a, b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero matrix, zero sum, extremes of every field, overflow.
    send_matrix('0, '0, '0);
    send_matrix(ONE, '0, -ONE);
    send_matrix(ONE, ONE, -ONE);
    send_matrix('0, MAXV, '0);
    send_matrix('0, MINV, '0);
    send_matrix(MAXV, '0, MINV);
    send_matrix(MINV, MINV, MINV);
    send_matrix(MAXV, MAXV, MAXV);
    send_matrix(MINV, MAXV, MAXV);
    send_matrix(MAXV, MINV, MINV);
    send_matrix(ONE, '0, ONE);
    send_matrix(2 * ONE, ONE, 2 * ONE);
    send_matrix(-ONE, ONE, -3 * ONE);
    send_matrix(1, 0, 0);
    send_matrix(-1, 1, 0);
    send_matrix(MAXV, '0, '0);
    send_matrix(MINV, '0, '0);
    send_matrix('1, '1, '1);
    send_matrix(ONE, 2 * ONE, 4 * ONE);  // singular: det zero
    send_matrix(3, 5, -3);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 71) : 0;
      recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 17 : 0;
      for (int i = 0; i < 120; i++) begin
        a = rand_entry();
        b = rand_entry();
        // Some zero-sum matrices
        send_matrix(a, b, ($urandom_range(9) == 0) ? -a : rand_entry());
      end
      if (ph == 1) wait_drained();  // sender pauses until all results are back
    end

    // Long receiver hold-off while the sender keeps pushing: fills and stalls input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 120; i++) send_matrix(rand_entry(), rand_entry(), rand_entry());

    wait_drained();
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0) begin
      $display("sym2x2_eigenvalues_core_test passed");
    end else begin
      $display("sym2x2_eigenvalues_core_test failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/s2e_pkg.sv
design/s2e_fifo.sv
design/s2e_front.sv
design/s2e_back.sv
design/sym2x2_eigenvalues_core.sv
tb/sv/sym2x2_eigenvalues_checker.sv
tb/sv/sym2x2_eigenvalues_core_test.sv
